### rtl/pme_pkg.sv
// pme_pkg: shared types, codes and reset values of the pheromone matrix engine
`default_nettype none

package pme_pkg;

    // default sizes handed to the top level parameters
    localparam int DEF_MAX_NODES  = 64;
    localparam int DEF_TRAIL_BITS = 48;

    // fixed field widths
    localparam int VALUE_W    = 48;
    localparam int OP_W       = 3;
    localparam int NODE_IDX_W = 6;
    localparam int CITY_W     = 7;
    localparam int KEEP_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // command codes
    localparam logic [OP_W-1:0] OP_DEPOSIT_DEFAULT = 3'd0;
    localparam logic [OP_W-1:0] OP_DEPOSIT_AMOUNT  = 3'd1;
    localparam logic [OP_W-1:0] OP_EVAP_ARC        = 3'd2;
    localparam logic [OP_W-1:0] OP_EVAP_ALL        = 3'd3;
    localparam logic [OP_W-1:0] OP_CLAMP_ALL       = 3'd4;
    localparam logic [OP_W-1:0] OP_FILL            = 3'd5;
    localparam logic [OP_W-1:0] OP_READ            = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CITY_COUNT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_FACTOR     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_DEPOSIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAIL_MAX       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAIL_MIN       = 3'd4;

    // configuration reset values
    localparam logic [CITY_W-1:0]  RST_CITY_COUNT      = 7'd64;
    localparam logic [KEEP_W-1:0]  RST_KEEP_FACTOR     = 16'd64225;
    localparam logic [VALUE_W-1:0] RST_DEFAULT_DEPOSIT = 48'd16777216;
    localparam logic [VALUE_W-1:0] RST_TRAIL_MAX       = 48'd167772160000000;
    localparam logic [VALUE_W-1:0] RST_TRAIL_MIN       = 48'd167772160000000;

    typedef struct packed {
        logic [OP_W-1:0]       op;
        logic [NODE_IDX_W-1:0] row;
        logic [NODE_IDX_W-1:0] col;
        logic [VALUE_W-1:0]    amount;
    } in_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               saturated;
    } out_item_t;

    typedef struct packed {
        logic [CITY_W-1:0]  city_count;
        logic [KEEP_W-1:0]  keep_factor;
        logic [VALUE_W-1:0] default_deposit;
        logic [VALUE_W-1:0] upper_limit;
        logic [VALUE_W-1:0] lower_limit;
    } cfg_t;

endpackage

`default_nettype wire

### rtl/pheromone_matrix_engine.sv
// pheromone_matrix_engine: top level, command sequencer around the trail memory
//
// Keeps a MAX_NODES x MAX_NODES matrix of unsigned Q24.24 pheromone trails in one
// synchronous ram and runs one command per input transfer, answering each with one
// result transfer. A read answers with the registered ram word, an unused code or
// an arc outside the active square with zero; a deposit writes the arc and then
// its mirror arc (the arc alone on the diagonal, where the mirror arc is the arc
// itself), and a single-arc evaporation passes through the registered keep-factor
// multiply before its write. The sweeps (evaporate all, clamp all, fill) stream the
// n x n active entries through the ram at one entry per cycle, n being the active
// node count; the ram's single write port and registered read set these steps.
// One command is in flight at a time; a finished result waits in the output
// register while the next command is taken. Matrix entries hold no defined value
// until a fill or a deposit has written them.
`default_nettype none

module pheromone_matrix_engine #(
    parameter int MAX_NODES  = pme_pkg::DEF_MAX_NODES,
    parameter int TRAIL_BITS = pme_pkg::DEF_TRAIL_BITS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [pme_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pme_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire pme_pkg::in_item_t              in_data,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output pme_pkg::out_item_t                  out_data
);

    localparam int DEPTH = MAX_NODES * MAX_NODES;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(MAX_NODES + 1);
    localparam int CW    = (NW > pme_pkg::CITY_W) ? NW : pme_pkg::CITY_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_EVAP,
        ST_MIRROR,
        ST_SWEEP,
        ST_HOLD
    } state_t;

    state_t                       state_reg;
    logic [pme_pkg::OP_W-1:0]     op_reg;
    logic                         in_sq_reg;
    logic [AW-1:0]                addr_a_reg;
    logic [AW-1:0]                addr_b_reg;
    logic [TRAIL_BITS-1:0]        amount_reg;
    logic [TRAIL_BITS-1:0]        sum_reg;
    logic                         sat_reg;
    pme_pkg::out_item_t           hold_reg;
    logic                         out_valid_reg;
    pme_pkg::out_item_t           out_data_reg;

    // sweep counters and pipeline
    logic [NW-1:0]                row_cnt_reg;
    logic [NW-1:0]                col_cnt_reg;
    logic                         issue_reg;
    logic                         s1_valid_reg;
    logic [AW-1:0]                s1_addr_reg;
    logic                         s2_valid_reg;
    logic [AW-1:0]                s2_addr_reg;
    logic [TRAIL_BITS-1:0]        s2_val_reg;

    pme_pkg::cfg_t                cfg;
    logic [NW-1:0]                node_count;
    logic [CW-1:0]                city_ext;
    logic [TRAIL_BITS-1:0]        t_max;
    logic [TRAIL_BITS-1:0]        t_min;
    logic [TRAIL_BITS-1:0]        t_default;

    logic                         in_accept;
    logic                         new_arc_op;
    logic                         new_sweep_op;
    logic                         new_in_sq;
    logic [AW-1:0]                new_addr_a;
    logic [AW-1:0]                new_addr_b;
    logic [AW-1:0]                sweep_addr;
    logic                         sweep_last_col;
    logic                         sweep_last_row;

    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    logic [TRAIL_BITS-1:0]        rd_data;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [TRAIL_BITS-1:0]        wr_data;

    logic                         op_is_deposit;
    logic [TRAIL_BITS-1:0]        dep_add;
    logic [TRAIL_BITS:0]          dep_sum;
    logic                         dep_sat;
    logic [TRAIL_BITS-1:0]        dep_val;
    logic                         scale_load;
    logic [TRAIL_BITS-1:0]        scaled;
    logic [TRAIL_BITS-1:0]        floored;
    logic [TRAIL_BITS-1:0]        clamp_hi;
    logic [TRAIL_BITS-1:0]        clamped;

    logic                         res_valid;
    pme_pkg::out_item_t           res_item;
    logic                         out_free;

    pme_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pme_ram #(
        .WIDTH (TRAIL_BITS),
        .DEPTH (DEPTH)
    ) u_trail_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pme_scale #(
        .TRAIL_BITS (TRAIL_BITS)
    ) u_scale (
        .clk    (clk),
        .load   (scale_load),
        .trail  (rd_data),
        .keep   (cfg.keep_factor),
        .scaled (scaled)
    );

    // active node count, limited to the matrix size
    assign city_ext   = CW'(cfg.city_count);
    assign node_count = (city_ext > CW'(MAX_NODES)) ? NW'(MAX_NODES) : NW'(city_ext);

    assign t_max     = TRAIL_BITS'(cfg.upper_limit);
    assign t_min     = TRAIL_BITS'(cfg.lower_limit);
    assign t_default = TRAIL_BITS'(cfg.default_deposit);

    // incoming command decode
    assign in_ready     = (state_reg == ST_IDLE);
    assign in_accept    = in_valid && in_ready;
    assign new_arc_op   = (in_data.op == pme_pkg::OP_DEPOSIT_DEFAULT)
                       || (in_data.op == pme_pkg::OP_DEPOSIT_AMOUNT)
                       || (in_data.op == pme_pkg::OP_EVAP_ARC)
                       || (in_data.op == pme_pkg::OP_READ);
    assign new_sweep_op = (in_data.op == pme_pkg::OP_EVAP_ALL)
                       || (in_data.op == pme_pkg::OP_CLAMP_ALL)
                       || (in_data.op == pme_pkg::OP_FILL);
    assign new_in_sq    = (CW'(in_data.row) < CW'(node_count))
                       && (CW'(in_data.col) < CW'(node_count));
    assign new_addr_a   = AW'(32'(in_data.row) * MAX_NODES + 32'(in_data.col));
    assign new_addr_b   = AW'(32'(in_data.col) * MAX_NODES + 32'(in_data.row));

    // sweep address walk
    assign sweep_addr     = AW'(AW'(row_cnt_reg) * AW'(MAX_NODES) + AW'(col_cnt_reg));
    assign sweep_last_col = (NW'(col_cnt_reg + 1'b1) == node_count);
    assign sweep_last_row = (NW'(row_cnt_reg + 1'b1) == node_count);

    // deposit with saturation at the top of the range
    assign op_is_deposit = (op_reg == pme_pkg::OP_DEPOSIT_DEFAULT)
                        || (op_reg == pme_pkg::OP_DEPOSIT_AMOUNT);
    assign dep_add = (op_reg == pme_pkg::OP_DEPOSIT_DEFAULT) ? t_default : amount_reg;
    assign dep_sum = {1'b0, rd_data} + {1'b0, dep_add};
    assign dep_sat = dep_sum[TRAIL_BITS];
    assign dep_val = dep_sat ? {TRAIL_BITS{1'b1}} : dep_sum[TRAIL_BITS-1:0];

    // evaporation floor and full clamp, upper limit first
    assign scale_load = (state_reg == ST_EXEC) || (state_reg == ST_SWEEP);
    assign floored    = (scaled < t_min) ? t_min : scaled;
    assign clamp_hi   = (rd_data > t_max) ? t_max : rd_data;
    assign clamped    = (clamp_hi < t_min) ? t_min : clamp_hi;

    assign out_free = !out_valid_reg || out_ready;

    // memory port steering and result formation
    always_comb
    begin
        rd_en     = 1'b0;
        rd_addr   = new_addr_a;
        wr_en     = 1'b0;
        wr_addr   = addr_a_reg;
        wr_data   = dep_val;
        res_valid = 1'b0;
        res_item  = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                rd_en = in_accept && new_arc_op && new_in_sq;
            end
            ST_EXEC:
            begin
                if (op_is_deposit && in_sq_reg)
                begin
                    wr_en = 1'b1;
                    if (addr_a_reg == addr_b_reg)
                    begin
                        res_valid          = 1'b1;
                        res_item.value     = pme_pkg::VALUE_W'(dep_val);
                        res_item.saturated = dep_sat;
                    end
                end
                else if (!((op_reg == pme_pkg::OP_EVAP_ARC) && in_sq_reg))
                begin
                    res_valid = 1'b1;
                    if ((op_reg == pme_pkg::OP_READ) && in_sq_reg)
                    begin
                        res_item.value = pme_pkg::VALUE_W'(rd_data);
                    end
                end
            end
            ST_EVAP:
            begin
                wr_en          = 1'b1;
                wr_data        = floored;
                res_valid      = 1'b1;
                res_item.value = pme_pkg::VALUE_W'(floored);
            end
            ST_MIRROR:
            begin
                wr_en              = 1'b1;
                wr_addr            = addr_b_reg;
                wr_data            = sum_reg;
                res_valid          = 1'b1;
                res_item.value     = pme_pkg::VALUE_W'(sum_reg);
                res_item.saturated = sat_reg;
            end
            ST_SWEEP:
            begin
                rd_en     = issue_reg;
                rd_addr   = sweep_addr;
                wr_en     = s2_valid_reg;
                wr_addr   = s2_addr_reg;
                wr_data   = (op_reg == pme_pkg::OP_EVAP_ALL) ? scaled : s2_val_reg;
                res_valid = !issue_reg && !s1_valid_reg;
            end
            ST_HOLD:
            begin
                res_valid = 1'b1;
                res_item  = hold_reg;
            end
            default:
            begin
            end
        endcase
    end

    // sequencer, sweep pipeline and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= '0;
            in_sq_reg     <= 1'b0;
            addr_a_reg    <= '0;
            addr_b_reg    <= '0;
            amount_reg    <= '0;
            sum_reg       <= '0;
            sat_reg       <= 1'b0;
            hold_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            row_cnt_reg   <= '0;
            col_cnt_reg   <= '0;
            issue_reg     <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s1_addr_reg   <= '0;
            s2_valid_reg  <= 1'b0;
            s2_addr_reg   <= '0;
            s2_val_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        op_reg      <= in_data.op;
                        in_sq_reg   <= new_in_sq;
                        addr_a_reg  <= new_addr_a;
                        addr_b_reg  <= new_addr_b;
                        amount_reg  <= TRAIL_BITS'(in_data.amount);
                        row_cnt_reg <= '0;
                        col_cnt_reg <= '0;
                        issue_reg   <= new_sweep_op && (node_count != '0);
                        state_reg   <= new_sweep_op ? ST_SWEEP : ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    if (op_is_deposit && in_sq_reg && (addr_a_reg != addr_b_reg))
                    begin
                        sum_reg   <= dep_val;
                        sat_reg   <= dep_sat;
                        state_reg <= ST_MIRROR;
                    end
                    else if ((op_reg == pme_pkg::OP_EVAP_ARC) && in_sq_reg)
                    begin
                        state_reg <= ST_EVAP;
                    end
                end
                ST_SWEEP:
                begin
                    if (issue_reg)
                    begin
                        if (sweep_last_col)
                        begin
                            col_cnt_reg <= '0;
                            if (sweep_last_row)
                            begin
                                issue_reg <= 1'b0;
                            end
                            else
                            begin
                                row_cnt_reg <= NW'(row_cnt_reg + 1'b1);
                            end
                        end
                        else
                        begin
                            col_cnt_reg <= NW'(col_cnt_reg + 1'b1);
                        end
                    end
                end
                ST_EVAP, ST_MIRROR, ST_HOLD:
                begin
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // finished command: hand to the output register or park it
            if (res_valid)
            begin
                if (out_free)
                begin
                    state_reg <= ST_IDLE;
                end
                else
                begin
                    hold_reg  <= res_item;
                    state_reg <= ST_HOLD;
                end
            end

            // output register
            if (res_valid && out_free)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= res_item;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // sweep pipeline: read, then compute, then write back
            s1_valid_reg <= (state_reg == ST_SWEEP) && issue_reg;
            s1_addr_reg  <= sweep_addr;
            s2_valid_reg <= s1_valid_reg;
            s2_addr_reg  <= s1_addr_reg;
            s2_val_reg   <= (op_reg == pme_pkg::OP_FILL) ? t_max : clamped;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

### rtl/pme_ram.sv
// pme_ram: generic simple dual port ram with registered read
`default_nettype none

module pme_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // read port, data held when not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/pme_cfg_regs.sv
// pme_cfg_regs: configuration register file written through the plain write port
`default_nettype none

module pme_cfg_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [pme_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pme_pkg::CFG_DATA_W-1:0]  cfg_data,
    output pme_pkg::cfg_t                        cfg
);

    pme_pkg::cfg_t cfg_reg;

    // register writes, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.city_count      <= pme_pkg::RST_CITY_COUNT;
            cfg_reg.keep_factor     <= pme_pkg::RST_KEEP_FACTOR;
            cfg_reg.default_deposit <= pme_pkg::RST_DEFAULT_DEPOSIT;
            cfg_reg.upper_limit     <= pme_pkg::RST_TRAIL_MAX;
            cfg_reg.lower_limit     <= pme_pkg::RST_TRAIL_MIN;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                pme_pkg::CFG_CITY_COUNT:
                    cfg_reg.city_count <= cfg_data[pme_pkg::CITY_W-1:0];
                pme_pkg::CFG_KEEP_FACTOR:
                    cfg_reg.keep_factor <= cfg_data[pme_pkg::KEEP_W-1:0];
                pme_pkg::CFG_DEFAULT_DEPOSIT:
                    cfg_reg.default_deposit <= cfg_data[pme_pkg::VALUE_W-1:0];
                pme_pkg::CFG_TRAIL_MAX:
                    cfg_reg.upper_limit <= cfg_data[pme_pkg::VALUE_W-1:0];
                pme_pkg::CFG_TRAIL_MIN:
                    cfg_reg.lower_limit <= cfg_data[pme_pkg::VALUE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/pme_scale.sv
// pme_scale: trail times keep factor in Q0.16, partial products registered
`default_nettype none

module pme_scale #(
    parameter int TRAIL_BITS = pme_pkg::DEF_TRAIL_BITS
) (
    input  wire logic                         clk,
    input  wire logic                         load,
    input  wire logic [TRAIL_BITS-1:0]        trail,
    input  wire logic [pme_pkg::KEEP_W-1:0]   keep,
    output logic      [TRAIL_BITS-1:0]        scaled
);

    localparam int HI_W  = (TRAIL_BITS > 32) ? TRAIL_BITS - 32 : 1;
    localparam int LO_PW = 32 + pme_pkg::KEEP_W;
    localparam int HI_PW = HI_W + pme_pkg::KEEP_W;

    logic [31:0]       lo_part;
    logic [HI_W-1:0]   hi_part;
    logic [LO_PW-1:0]  prod_lo_next;
    logic [HI_PW-1:0]  prod_hi_next;
    logic [LO_PW-1:0]  prod_lo_reg;
    logic [HI_PW-1:0]  prod_hi_reg;

    // split the trail into a low word and the bits above it
    assign lo_part      = trail[31:0];
    assign hi_part      = HI_W'(trail >> 32);
    assign prod_lo_next = LO_PW'(lo_part) * LO_PW'(keep);
    assign prod_hi_next = HI_PW'(hi_part) * HI_PW'(keep);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_lo_reg <= prod_lo_next;
            prod_hi_reg <= prod_hi_next;
        end
    end

    // recombine: (hi * k) << 16 plus (lo * k) >> 16, exact truncation
    assign scaled = TRAIL_BITS'({prod_hi_reg, 16'b0})
                  + TRAIL_BITS'(prod_lo_reg >> pme_pkg::KEEP_W);

endmodule

`default_nettype wire
